### rtl/gf2_column_reduction_macros.svh
// ----------------------------------------------------------------------------
// GF(2) column reduction assertion macros
// Concurrent assertion wrappers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GF2_COLUMN_REDUCTION_MACROS_SVH
`define GF2_COLUMN_REDUCTION_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define GCR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define GCR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define GCR_ASSERT(label, clk, rst_n, prop, msg)
`define GCR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// GF(2) column reduction package
// Shared widths, register indexes, error codes and types.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int DEF_ROWS    = 64;
    localparam int ROW_W       = 6;
    localparam int RANK_W      = 7;
    localparam int ERR_W       = 3;
    localparam int COL_CNT_W   = 16;
    localparam int STORE_CNT_W = 13;
    localparam int XOR_CNT_W   = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_REDUCED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_ENTRY_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_STEP_LIMIT     = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_ORDER = 3'd1;
    localparam logic [ERR_W-1:0] ERR_INPUT = 3'd2;
    localparam logic [ERR_W-1:0] ERR_STORE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_WORK  = 3'd4;

    typedef struct packed {
        logic                   emit_reduced;
        logic [COL_CNT_W-1:0]   column_limit;
        logic [STORE_CNT_W-1:0] stored_entry_limit;
        logic [XOR_CNT_W-1:0]   xor_step_limit;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/gcr_in_if.sv
// ----------------------------------------------------------------------------
// Column entry channel
// Valid/ready channel that carries one row entry request of a column.
// ----------------------------------------------------------------------------
interface gcr_in_if;

    logic                      valid;
    logic                      ready;
    logic [gcr_pkg::ROW_W-1:0] row_index;
    logic                      has_entry;
    logic                      end_of_column;
    logic                      first_of_matrix;

    modport source (
        output valid,
        input  ready,
        output row_index,
        output has_entry,
        output end_of_column,
        output first_of_matrix
    );

    modport sink (
        input  valid,
        output ready,
        input  row_index,
        input  has_entry,
        input  end_of_column,
        input  first_of_matrix
    );

endinterface

### rtl/gcr_out_if.sv
// ----------------------------------------------------------------------------
// Column result channel
// Valid/ready channel that carries one reduced column result request.
// ----------------------------------------------------------------------------
interface gcr_out_if #(
    parameter int ROWS = gcr_pkg::DEF_ROWS
);

    logic                       valid;
    logic                       ready;
    logic [ROWS-1:0]            reduced_bits;
    logic [gcr_pkg::ROW_W-1:0]  low_row;
    logic                       column_zero;
    logic [gcr_pkg::RANK_W-1:0] rank_so_far;
    logic [gcr_pkg::ERR_W-1:0]  error_code;

    modport source (
        output valid,
        input  ready,
        output reduced_bits,
        output low_row,
        output column_zero,
        output rank_so_far,
        output error_code
    );

    modport sink (
        input  valid,
        output ready,
        input  reduced_bits,
        input  low_row,
        input  column_zero,
        input  rank_so_far,
        input  error_code
    );

endinterface

### rtl/gcr_front.sv
// ----------------------------------------------------------------------------
// GF(2) column reduction front end
// Collects row entries into a dense column, checks row order and hands each
// finished column to the queue together with its order error and clear mark.
// ----------------------------------------------------------------------------
module gcr_front #(
    parameter int ROWS = gcr_pkg::DEF_ROWS
) (
    input  logic                clk,
    input  logic                rst_n,
    gcr_in_if.sink              col_in,
    input  gcr_pkg::q_status_t  q_status,
    output logic                q_push,
    output logic [ROWS+1:0]     q_data
);

    localparam int PREV_W = gcr_pkg::ROW_W + 1;

    logic [ROWS-1:0]   acc_reg;
    logic [ROWS-1:0]   acc_next;
    logic [PREV_W-1:0] prev_reg;
    logic [PREV_W-1:0] prev_next;
    logic              err_reg;
    logic              err_next;
    logic              clear_reg;
    logic              clear_next;

    logic              accept;
    logic [ROWS-1:0]   base_acc;
    logic [PREV_W-1:0] base_prev;
    logic              base_err;
    logic              base_clear;
    logic [PREV_W-1:0] row_ext;
    logic              row_ok;

    assign col_in.ready = !q_status.full;
    assign accept       = col_in.valid && col_in.ready;
    assign row_ext      = {1'b0, col_in.row_index};

    always_comb
    begin
        base_acc   = col_in.first_of_matrix ? '0 : acc_reg;
        base_prev  = col_in.first_of_matrix ? '0 : prev_reg;
        base_err   = col_in.first_of_matrix ? 1'b0 : err_reg;
        base_clear = col_in.first_of_matrix | clear_reg;
        row_ok     = (row_ext < PREV_W'(ROWS)) && ((row_ext + PREV_W'(1)) > base_prev);

        acc_next   = acc_reg;
        prev_next  = prev_reg;
        err_next   = err_reg;
        clear_next = clear_reg;
        q_push     = 1'b0;
        q_data     = '0;

        if (accept)
        begin
            acc_next   = base_acc;
            prev_next  = base_prev;
            err_next   = base_err;
            clear_next = base_clear;

            // Once a column has an order error its later entries are dropped.
            if (col_in.has_entry && !base_err)
            begin
                if (row_ok)
                begin
                    for (int i = 0; i < ROWS; i++)
                    begin
                        if (col_in.row_index == gcr_pkg::ROW_W'(i))
                        begin
                            acc_next[i] = 1'b1;
                        end
                    end
                    prev_next = row_ext + PREV_W'(1);
                end
                else
                begin
                    err_next = 1'b1;
                end
            end

            if (col_in.end_of_column)
            begin
                q_push     = 1'b1;
                q_data     = {clear_next, err_next, acc_next};
                acc_next   = '0;
                prev_next  = '0;
                err_next   = 1'b0;
                clear_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            prev_reg  <= '0;
            err_reg   <= 1'b0;
            clear_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            prev_reg  <= prev_next;
            err_reg   <= err_next;
            clear_reg <= clear_next;
        end
    end

endmodule

### rtl/gcr_fifo.sv
// ----------------------------------------------------------------------------
// GF(2) column reduction column queue
// Short first-in first-out queue of finished columns between front and back.
// ----------------------------------------------------------------------------
module gcr_fifo #(
    parameter int WIDTH = gcr_pkg::DEF_ROWS + 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output gcr_pkg::q_status_t status
);

    localparam int DEPTH = gcr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/gcr_back.sv
// ----------------------------------------------------------------------------
// GF(2) column reduction back end
// Takes finished columns from the queue, applies the matrix counters and
// budgets, reduces each column against the pivot memory and registers the
// result for the output channel.
// ----------------------------------------------------------------------------
`include "gf2_column_reduction_macros.svh"

module gcr_back #(
    parameter int ROWS = gcr_pkg::DEF_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gcr_pkg::cfg_t      cfg,
    input  gcr_pkg::q_status_t q_status,
    input  logic [ROWS+1:0]    q_data,
    output logic               q_pop,
    gcr_out_if.source          res_out
);

    localparam int IDX_W = $clog2(ROWS);
    localparam int POP_W = $clog2(ROWS + 1);
    localparam int SUM_W = gcr_pkg::STORE_CNT_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TOP  = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [ROWS-1:0]                   acc_reg;
    logic [ROWS-1:0]                   acc_next;
    logic                              after_xor_reg;
    logic                              after_xor_next;
    logic                              ok_reg;
    logic                              ok_next;
    logic [IDX_W-1:0]                  top_reg;
    logic [IDX_W-1:0]                  top_next;
    logic [POP_W-1:0]                  pop_reg;
    logic [POP_W-1:0]                  pop_next;
    logic [ROWS-1:0]                   pivot_valid_reg;
    logic [ROWS-1:0]                   pivot_valid_next;
    logic [gcr_pkg::XOR_CNT_W-1:0]     xor_count_reg;
    logic [gcr_pkg::XOR_CNT_W-1:0]     xor_count_next;
    logic [gcr_pkg::STORE_CNT_W-1:0]   stored_reg;
    logic [gcr_pkg::STORE_CNT_W-1:0]   stored_next;
    logic [gcr_pkg::COL_CNT_W-1:0]     col_count_reg;
    logic [gcr_pkg::COL_CNT_W-1:0]     col_count_next;
    logic [gcr_pkg::RANK_W-1:0]        pivot_count_reg;
    logic [gcr_pkg::RANK_W-1:0]        pivot_count_next;
    logic [gcr_pkg::ERR_W-1:0]         sticky_reg;
    logic [gcr_pkg::ERR_W-1:0]         sticky_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [ROWS-1:0]                   out_bits_reg;
    logic [gcr_pkg::ROW_W-1:0]         out_low_reg;
    logic                              out_zero_reg;
    logic [gcr_pkg::RANK_W-1:0]        out_rank_reg;
    logic [gcr_pkg::ERR_W-1:0]         out_err_reg;
    logic                              out_load;

    logic [ROWS-1:0]                   pivot_mem [ROWS];
    logic [ROWS-1:0]                   rd_data_reg;
    logic                              rd_en;
    logic                              mem_we;

    logic [IDX_W-1:0]                  top_comb;
    logic [POP_W-1:0]                  pop_comb;
    logic                              rec_clear;
    logic                              rec_order_err;
    logic [ROWS-1:0]                   rec_bits;
    logic                              clear_take;
    logic [gcr_pkg::COL_CNT_W-1:0]     base_count;
    logic [gcr_pkg::ERR_W-1:0]         new_err;
    logic [SUM_W-1:0]                  stored_ext;
    logic [SUM_W-1:0]                  limit_ext;

    assign rec_clear     = q_data[ROWS+1];
    assign rec_order_err = q_data[ROWS];
    assign rec_bits      = q_data[ROWS-1:0];
    assign clear_take    = q_pop && rec_clear;
    assign stored_ext    = {1'b0, stored_reg};
    assign limit_ext     = {1'b0, cfg.stored_entry_limit};

    // Highest set row and set-bit count of the working column.
    always_comb
    begin
        top_comb = '0;
        pop_comb = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            if (acc_reg[i])
            begin
                top_comb = IDX_W'(i);
            end
            pop_comb = pop_comb + POP_W'(acc_reg[i]);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        after_xor_next   = after_xor_reg;
        ok_next          = ok_reg;
        top_next         = top_reg;
        pop_next         = pop_reg;
        pivot_valid_next = pivot_valid_reg;
        xor_count_next   = xor_count_reg;
        stored_next      = stored_reg;
        col_count_next   = col_count_reg;
        pivot_count_next = pivot_count_reg;
        sticky_next      = sticky_reg;
        q_pop            = 1'b0;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        out_load         = 1'b0;
        base_count       = '0;
        new_err          = gcr_pkg::ERR_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    // A new matrix starts from empty pivots and counters.
                    if (rec_clear)
                    begin
                        pivot_valid_next = '0;
                        xor_count_next   = '0;
                        stored_next      = '0;
                        pivot_count_next = '0;
                    end
                    base_count = rec_clear ? '0 : col_count_reg;
                    new_err    = rec_clear ? gcr_pkg::ERR_NONE : sticky_reg;
                    if (new_err == gcr_pkg::ERR_NONE && rec_order_err)
                    begin
                        new_err = gcr_pkg::ERR_ORDER;
                    end
                    if (base_count != '1)
                    begin
                        base_count = base_count + gcr_pkg::COL_CNT_W'(1);
                    end
                    if (new_err == gcr_pkg::ERR_NONE && base_count > cfg.column_limit)
                    begin
                        new_err = gcr_pkg::ERR_INPUT;
                    end
                    col_count_next = base_count;
                    sticky_next    = new_err;
                    acc_next       = rec_bits;
                    after_xor_next = 1'b0;
                    if (new_err == gcr_pkg::ERR_NONE)
                    begin
                        state_next = S_TOP;
                    end
                    else
                    begin
                        ok_next    = 1'b0;
                        state_next = S_OUT;
                    end
                end
            end

            S_TOP:
            begin
                after_xor_next = 1'b0;
                // A non-empty XOR result must still fit the storage budget.
                if (after_xor_reg && pop_comb != '0
                    && (stored_ext + SUM_W'(pop_comb)) > limit_ext)
                begin
                    sticky_next = gcr_pkg::ERR_WORK;
                    ok_next     = 1'b0;
                    state_next  = S_OUT;
                end
                else
                begin
                    if (after_xor_reg)
                    begin
                        xor_count_next = xor_count_reg + gcr_pkg::XOR_CNT_W'(1);
                    end
                    if (acc_reg == '0)
                    begin
                        ok_next    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        top_next   = top_comb;
                        pop_next   = pop_comb;
                        rd_en      = 1'b1;
                        state_next = S_DEC;
                    end
                end
            end

            S_DEC:
            begin
                if (!pivot_valid_reg[top_reg])
                begin
                    if ((stored_ext + SUM_W'(pop_reg)) > limit_ext)
                    begin
                        sticky_next = gcr_pkg::ERR_STORE;
                        ok_next     = 1'b0;
                    end
                    else
                    begin
                        mem_we                    = 1'b1;
                        pivot_valid_next[top_reg] = 1'b1;
                        stored_next      = stored_reg + gcr_pkg::STORE_CNT_W'(pop_reg);
                        pivot_count_next = pivot_count_reg + gcr_pkg::RANK_W'(1);
                        ok_next          = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (xor_count_reg >= cfg.xor_step_limit)
                begin
                    sticky_next = gcr_pkg::ERR_WORK;
                    ok_next     = 1'b0;
                    state_next  = S_OUT;
                end
                else
                begin
                    acc_next       = acc_reg ^ rd_data_reg;
                    after_xor_next = 1'b1;
                    state_next     = S_TOP;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pivot_mem[top_reg] <= acc_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= pivot_mem[top_comb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bits_reg <= (ok_reg && cfg.emit_reduced) ? acc_reg : '0;
            out_low_reg  <= (ok_reg && acc_reg != '0) ? gcr_pkg::ROW_W'(top_comb) : '0;
            out_zero_reg <= ok_reg && (acc_reg == '0);
            out_rank_reg <= pivot_count_reg;
            out_err_reg  <= sticky_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            acc_reg         <= '0;
            after_xor_reg   <= 1'b0;
            ok_reg          <= 1'b0;
            top_reg         <= '0;
            pop_reg         <= '0;
            pivot_valid_reg <= '0;
            xor_count_reg   <= '0;
            stored_reg      <= '0;
            col_count_reg   <= '0;
            pivot_count_reg <= '0;
            sticky_reg      <= gcr_pkg::ERR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            acc_reg         <= acc_next;
            after_xor_reg   <= after_xor_next;
            ok_reg          <= ok_next;
            top_reg         <= top_next;
            pop_reg         <= pop_next;
            pivot_valid_reg <= pivot_valid_next;
            xor_count_reg   <= xor_count_next;
            stored_reg      <= stored_next;
            col_count_reg   <= col_count_next;
            pivot_count_reg <= pivot_count_next;
            sticky_reg      <= sticky_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.reduced_bits = out_bits_reg;
    assign res_out.low_row      = out_low_reg;
    assign res_out.column_zero  = out_zero_reg;
    assign res_out.rank_so_far  = out_rank_reg;
    assign res_out.error_code   = out_err_reg;

    // The rank always matches the number of occupied pivot slots.
    `GCR_ASSERT(a_rank_matches_valid, clk, rst_n, pivot_count_reg == $countones(pivot_valid_reg), "rank differs from pivot slot count")

    // A pivot slot is written only while it is still free.
    `GCR_ASSERT_ALWAYS(a_write_free_slot, clk, mem_we |-> !pivot_valid_reg[top_reg], "pivot slot overwritten")

    // An error code holds until a new matrix starts.
    `GCR_ASSERT(a_error_sticky, clk, rst_n, (sticky_reg != gcr_pkg::ERR_NONE && !clear_take) |=> (sticky_reg == $past(sticky_reg)), "error code changed inside a matrix")

    // Reduction only runs on a column that has no error.
    `GCR_ASSERT(a_reduce_clean, clk, rst_n, (state_reg == S_TOP || state_reg == S_DEC) |-> (sticky_reg == gcr_pkg::ERR_NONE), "reduction running with an error set")

endmodule

### rtl/gf2_column_reduction.sv
// ----------------------------------------------------------------------------
// GF(2) column reduction
// Reduces the columns of a binary matrix against stored pivot columns and
// reports one result per column with rank and a sticky error code.
//
//   Channel   Dir   Request carries
//   col_in    in    row_index, has_entry, end_of_column, first_of_matrix
//   res_out   out   reduced_bits, low_row, column_zero, rank_so_far, error_code
//   cfg_*     in    register index and write data, no handshake
//
// The front end takes an entry request whenever the queue is not full.
// A column end is taken from the queue by the back end; each pivot lookup
// (k lookups, k <= ROWS) finds the top row and then reads the pivot memory,
// a further top-row step follows when the column ends empty or its last XOR
// result breaks the storage budget, and then the result register is loaded.
// Reset clears all control state and the pivot slot valid bits; the pivot
// memory itself is not cleared.
// A two-column queue lets the front keep taking entries while the back end
// reduces or waits on a stalled output.
// ----------------------------------------------------------------------------
module gf2_column_reduction #(
    parameter int ROWS = gcr_pkg::DEF_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gcr_in_if.sink                         col_in,
    gcr_out_if.source                      res_out,
    input  logic                           cfg_write,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int REC_W = ROWS + 2;

    gcr_pkg::cfg_t      cfg_reg;
    gcr_pkg::cfg_t      cfg_next;
    gcr_pkg::q_status_t q_status;
    logic               q_push;
    logic [REC_W-1:0]   q_push_data;
    logic               q_pop;
    logic [REC_W-1:0]   q_pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                gcr_pkg::REG_EMIT_REDUCED:
                begin
                    cfg_next.emit_reduced = cfg_data[0];
                end
                gcr_pkg::REG_COLUMN_LIMIT:
                begin
                    cfg_next.column_limit = cfg_data[gcr_pkg::COL_CNT_W-1:0];
                end
                gcr_pkg::REG_STORED_ENTRY_LIMIT:
                begin
                    cfg_next.stored_entry_limit = cfg_data[gcr_pkg::STORE_CNT_W-1:0];
                end
                gcr_pkg::REG_XOR_STEP_LIMIT:
                begin
                    cfg_next.xor_step_limit = cfg_data[gcr_pkg::XOR_CNT_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emit_reduced       <= 1'b1;
            cfg_reg.column_limit       <= 16'hFFFF;
            cfg_reg.stored_entry_limit <= 13'd4096;
            cfg_reg.xor_step_limit     <= 32'hFFFF_FFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gcr_front #(
        .ROWS (ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .col_in   (col_in),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    gcr_fifo #(
        .WIDTH (REC_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    gcr_back #(
        .ROWS (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .res_out  (res_out)
    );

endmodule

### verif/tb_gf2_column_reduction.sv
// ----------------------------------------------------------------------------
// GF(2) column reduction testbench
// Streams row entries of sparse binary columns into the block and checks
// each column result against a built-in predictor of the pivot reduction.
// Random stalls on both channels, config phases that sweep the budget
// limits, malformed columns and mid-column matrix restarts are all covered.
// ----------------------------------------------------------------------------
module tb_gf2_column_reduction;

    localparam int ROWS          = gcr_pkg::DEF_ROWS;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASE_ITEMS   = 180;
    localparam int MAX_GAP       = 16;
    // Worst-case back end time for one column, doubled for the queued one.
    localparam int SETTLE_CYCLES = 2 * (3 + 2 * ROWS) + MAX_GAP + 4;

    typedef struct packed {
        logic [gcr_pkg::ROW_W-1:0] row_index;
        logic                      has_entry;
        logic                      end_of_column;
        logic                      first_of_matrix;
    } column_entry_t;

    typedef struct packed {
        logic [ROWS-1:0]            reduced_bits;
        logic [gcr_pkg::ROW_W-1:0]  low_row;
        logic                       column_zero;
        logic [gcr_pkg::RANK_W-1:0] rank_so_far;
        logic [gcr_pkg::ERR_W-1:0]  error_code;
    } column_result_t;

    class reduction_scoreboard;
        bit                            emit_reduced;
        bit [gcr_pkg::COL_CNT_W-1:0]   column_limit;
        bit [gcr_pkg::STORE_CNT_W-1:0] stored_entry_limit;
        bit [gcr_pkg::XOR_CNT_W-1:0]   xor_step_limit;

        bit [ROWS-1:0]                 column_bits;
        int unsigned                   previous_row;
        bit [ROWS-1:0]                 pivot_column [ROWS];
        bit                            pivot_present [ROWS];
        bit [gcr_pkg::XOR_CNT_W-1:0]   xor_done;
        int unsigned                   stored_bits;
        bit [gcr_pkg::COL_CNT_W-1:0]   columns_seen;
        bit [gcr_pkg::RANK_W-1:0]      rank;
        bit [gcr_pkg::ERR_W-1:0]       sticky_error;

        column_result_t                pending_results [$];
        int unsigned                   mismatches;

        function new();
            emit_reduced       = 1'b1;
            column_limit       = '1;
            stored_entry_limit = 13'd4096;
            xor_step_limit     = '1;
            mismatches         = 0;
            clear_matrix();
        endfunction

        function void clear_matrix();
            column_bits  = '0;
            previous_row = 0;
            xor_done     = '0;
            stored_bits  = 0;
            columns_seen = '0;
            rank         = '0;
            sticky_error = gcr_pkg::ERR_NONE;
            for (int i = 0; i < ROWS; i++)
                pivot_present[i] = 1'b0;
        endfunction

        function int unsigned top_row(input bit [ROWS-1:0] bits);
            int unsigned t;
            t = 0;
            for (int i = 0; i < ROWS; i++)
                if (bits[i])
                    t = i;
            return t;
        endfunction

        function void flag_error(input bit [gcr_pkg::ERR_W-1:0] code);
            if (sticky_error == gcr_pkg::ERR_NONE)
                sticky_error = code;
        endfunction

        function void set_register(input logic [gcr_pkg::CFG_IDX_W-1:0] index,
                                   input logic [gcr_pkg::CFG_DATA_W-1:0] value);
            case (index)
                gcr_pkg::REG_EMIT_REDUCED:
                    emit_reduced = value[0];
                gcr_pkg::REG_COLUMN_LIMIT:
                    column_limit = value[gcr_pkg::COL_CNT_W-1:0];
                gcr_pkg::REG_STORED_ENTRY_LIMIT:
                    stored_entry_limit = value[gcr_pkg::STORE_CNT_W-1:0];
                gcr_pkg::REG_XOR_STEP_LIMIT:
                    xor_step_limit = value[gcr_pkg::XOR_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Eliminates the column against stored pivots; 0 when a budget trips.
        function bit reduce_against_pivots();
            bit [ROWS-1:0] acc;
            int unsigned   top;
            int unsigned   pop;
            acc = column_bits;
            while (acc != '0) begin
                top = top_row(acc);
                pop = $countones(acc);
                if (!pivot_present[top]) begin
                    if (stored_bits + pop > stored_entry_limit) begin
                        flag_error(gcr_pkg::ERR_STORE);
                        return 1'b0;
                    end
                    stored_bits        += pop;
                    pivot_column[top]   = acc;
                    pivot_present[top]  = 1'b1;
                    rank++;
                    break;
                end
                if (xor_done >= xor_step_limit) begin
                    flag_error(gcr_pkg::ERR_WORK);
                    return 1'b0;
                end
                acc ^= pivot_column[top];
                pop  = $countones(acc);
                // A partial sum that could never be stored counts against the work budget.
                if (pop != 0 && stored_bits + pop > stored_entry_limit) begin
                    flag_error(gcr_pkg::ERR_WORK);
                    return 1'b0;
                end
                xor_done++;
            end
            column_bits = acc;
            return 1'b1;
        endfunction

        function void absorb_entry(input column_entry_t e);
            column_result_t want;
            bit             ok;
            if (e.first_of_matrix)
                clear_matrix();
            if (e.has_entry && sticky_error == gcr_pkg::ERR_NONE) begin
                if (e.row_index >= ROWS || e.row_index + 1 <= previous_row) begin
                    flag_error(gcr_pkg::ERR_ORDER);
                end else begin
                    column_bits[e.row_index] = 1'b1;
                    previous_row             = e.row_index + 1;
                end
            end
            if (!e.end_of_column)
                return;
            if (columns_seen != '1)
                columns_seen++;
            if (sticky_error == gcr_pkg::ERR_NONE && columns_seen > column_limit)
                flag_error(gcr_pkg::ERR_INPUT);
            ok = 1'b0;
            if (sticky_error == gcr_pkg::ERR_NONE)
                ok = reduce_against_pivots();
            want = '0;
            if (ok) begin
                want.reduced_bits = emit_reduced ? column_bits : '0;
                want.low_row      = (column_bits != '0) ?
                                    gcr_pkg::ROW_W'(top_row(column_bits)) : '0;
                want.column_zero  = (column_bits == '0);
            end
            want.rank_so_far = rank;
            want.error_code  = sticky_error;
            pending_results.insert(pending_results.size(), want);
            column_bits  = '0;
            previous_row = 0;
        endfunction

        function void check_column_result(input column_result_t got);
            column_result_t want;
            if (pending_results.size() == 0) begin
                $error("result with no column pending: low_row %0d error_code %0d",
                       got.low_row, got.error_code);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.reduced_bits !== want.reduced_bits) begin
                $error("reduced_bits: expected %h, actual %h",
                       want.reduced_bits, got.reduced_bits);
                mismatches++;
            end
            if (got.low_row !== want.low_row) begin
                $error("low_row: expected %0d, actual %0d", want.low_row, got.low_row);
                mismatches++;
            end
            if (got.column_zero !== want.column_zero) begin
                $error("column_zero: expected %0d, actual %0d",
                       want.column_zero, got.column_zero);
                mismatches++;
            end
            if (got.rank_so_far !== want.rank_so_far) begin
                $error("rank_so_far: expected %0d, actual %0d",
                       want.rank_so_far, got.rank_so_far);
                mismatches++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code: expected %0d, actual %0d",
                       want.error_code, got.error_code);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gcr_pkg::CFG_DATA_W-1:0] cfg_data;

    gcr_in_if                     col_in ();
    gcr_out_if #(.ROWS(ROWS))     res_out ();

    gf2_column_reduction #(.ROWS(ROWS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_in    (col_in),
        .res_out   (res_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    reduction_scoreboard sb;
    bit                  no_idle;
    int unsigned         stimulus_items;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Entry channel
    // ------------------------------------------------------------------
    task automatic send_item(input int unsigned row, input logic has,
                             input logic eoc, input logic first);
        column_entry_t e;
        int unsigned   gap;
        e   = '{row_index: gcr_pkg::ROW_W'(row), has_entry: has,
                end_of_column: eoc, first_of_matrix: first};
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            col_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        col_in.valid           <= 1'b1;
        col_in.row_index       <= e.row_index;
        col_in.has_entry       <= e.has_entry;
        col_in.end_of_column   <= e.end_of_column;
        col_in.first_of_matrix <= e.first_of_matrix;
        do @(posedge clk); while (col_in.ready !== 1'b1);
        sb.absorb_entry(e);
        stimulus_items++;
    endtask

    // Sends the set rows in ascending order, sometimes with blank requests
    // mixed in and sometimes closing the column with a blank request.
    task automatic send_column(input bit first, input bit [ROWS-1:0] bits);
        int unsigned last;
        bit          lead;
        bit          split_end;
        if (bits == '0) begin
            send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b1, first);
            return;
        end
        last = 0;
        for (int r = 0; r < ROWS; r++)
            if (bits[r])
                last = r;
        split_end = ($urandom_range(0, 7) == 0);
        lead      = first;
        for (int r = 0; r < ROWS; r++) begin
            if (bits[r]) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b0, lead);
                    lead = 1'b0;
                end
                send_item(r, 1'b1, (r == last) && !split_end, lead);
                lead = 1'b0;
            end
        end
        if (split_end)
            send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b1, 1'b0);
    endtask

    task automatic run_matrix(input int unsigned columns);
        int unsigned   base;
        int unsigned   span;
        int unsigned   picks;
        int unsigned   r;
        bit            wide;
        bit            first;
        bit [ROWS-1:0] bits;
        wide  = ($urandom_range(0, 5) == 0);
        base  = wide ? 0 : $urandom_range(0, ROWS - 1);
        span  = wide ? ROWS : $urandom_range(2, 14);
        first = 1'b1;
        for (int c = 0; c < columns; c++) begin
            case ($urandom_range(0, 19))
                0: begin
                    // Repeated or descending row inside one column.
                    r = $urandom_range(1, ROWS - 1);
                    send_item(r, 1'b1, 1'b0, first);
                    send_item($urandom_range(0, r), 1'b1, 1'b1, 1'b0);
                end
                1: send_column(first, '0);
                default: begin
                    // A narrow row window makes lowest rows collide often.
                    bits  = '0;
                    picks = $urandom_range(1, wide ? 6 : 4);
                    for (int k = 0; k < picks; k++)
                        bits[(base + $urandom_range(0, span - 1)) % ROWS] = 1'b1;
                    send_column(first, bits);
                end
            endcase
            first = 1'b0;
        end
        // Leave a column unfinished; the next matrix start discards it.
        if ($urandom_range(0, 4) == 0)
            send_item($urandom_range(0, ROWS - 1), 1'b1, 1'b0, 1'b0);
    endtask

    task automatic wait_for_results();
        col_in.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [gcr_pkg::CFG_IDX_W-1:0] index,
                             input logic [gcr_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(index, value);
    endtask

    task automatic program_block(input int unsigned emit, input int unsigned columns,
                                 input int unsigned stored, input int unsigned steps);
        write_reg(gcr_pkg::REG_EMIT_REDUCED, gcr_pkg::CFG_DATA_W'(emit));
        write_reg(gcr_pkg::REG_COLUMN_LIMIT, gcr_pkg::CFG_DATA_W'(columns));
        write_reg(gcr_pkg::REG_STORED_ENTRY_LIMIT, gcr_pkg::CFG_DATA_W'(stored));
        write_reg(gcr_pkg::REG_XOR_STEP_LIMIT, gcr_pkg::CFG_DATA_W'(steps));
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        res_out.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                res_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_out.ready <= 1'b1;
            do @(posedge clk); while (!(res_out.valid === 1'b1 && res_out.ready === 1'b1));
        end
    end

    always @(posedge clk) begin
        column_result_t seen;
        if (rst_n === 1'b1 && res_out.valid === 1'b1 && res_out.ready === 1'b1) begin
            seen.reduced_bits = res_out.reduced_bits;
            seen.low_row      = res_out.low_row;
            seen.column_zero  = res_out.column_zero;
            seen.rank_so_far  = res_out.rank_so_far;
            seen.error_code   = res_out.error_code;
            sb.check_column_result(seen);
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned goal;
        int unsigned phase_end;
        sb             = new();
        no_idle        = 1'b0;
        stimulus_items = 0;
        rst_n                  <= 1'b0;
        col_in.valid           <= 1'b0;
        col_in.row_index       <= '0;
        col_in.has_entry       <= 1'b0;
        col_in.end_of_column   <= 1'b0;
        col_in.first_of_matrix <= 1'b0;
        cfg_write              <= 1'b0;
        cfg_index              <= gcr_pkg::REG_EMIT_REDUCED;
        cfg_data               <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty column, extreme rows, elimination down to zero.
        send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b1, 1'b1);
        send_item(0, 1'b1, 1'b1, 1'b0);
        send_item(0, 1'b1, 1'b0, 1'b0);
        send_item(ROWS - 1, 1'b1, 1'b1, 1'b0);
        send_item(ROWS - 1, 1'b1, 1'b1, 1'b0);
        send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b0, 1'b0);
        // Blank request inside a column, then a blank request closing it.
        send_item(10, 1'b1, 1'b0, 1'b0);
        send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b0, 1'b0);
        send_item(20, 1'b1, 1'b0, 1'b0);
        send_item($urandom_range(0, ROWS - 1), 1'b0, 1'b1, 1'b0);
        // New matrix starting in the middle of a column.
        send_item(7, 1'b1, 1'b0, 1'b0);
        send_item(9, 1'b1, 1'b1, 1'b1);
        // Repeated row, then a column that only sees the sticky error.
        send_item(42, 1'b1, 1'b0, 1'b0);
        send_item(42, 1'b1, 1'b1, 1'b0);
        send_item(5, 1'b1, 1'b1, 1'b0);
        send_item(2, 1'b1, 1'b0, 1'b1);
        send_item(1, 1'b1, 1'b1, 1'b0);
        send_item(33, 1'b1, 1'b1, 1'b1);

        // Tight budgets: a blocked XOR step and an overfull pivot store.
        wait_for_results();
        program_block(1'b0, '1, 13'd2, '0);
        send_item(4, 1'b1, 1'b1, 1'b1);
        send_item(4, 1'b1, 1'b1, 1'b0);
        send_item(1, 1'b1, 1'b0, 1'b1);
        send_item(2, 1'b1, 1'b1, 1'b0);
        send_item(3, 1'b1, 1'b1, 1'b0);

        goal  = stimulus_items + RANDOM_ITEMS;
        phase = 0;
        while (stimulus_items < goal) begin
            // Every phase change holds the sender until all results are back.
            wait_for_results();
            case (phase % 6)
                0: program_block(1'b1, '1, 13'd4096, '1);
                1: program_block(1'b0, $urandom_range(2, 30), $urandom_range(8, 80),
                                 $urandom_range(0, 20));
                2: program_block(1'b1, '0, '0, '0);
                3: program_block($urandom_range(0, 1), $urandom_range(5, 40), 13'd4096,
                                 $urandom_range(1, 8));
                4: program_block(1'b0, '1, $urandom_range(20, 200), '1);
                default: program_block($urandom_range(0, 1), $urandom_range(0, 65535),
                                       $urandom_range(0, 4096), $urandom);
            endcase
            no_idle   = (phase % 4 == 3);
            phase_end = stimulus_items + PHASE_ITEMS;
            while (stimulus_items < phase_end && stimulus_items < goal)
                run_matrix($urandom_range(3, 30));
            phase++;
        end
        no_idle = 1'b0;
        wait_for_results();

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### gf2_column_reduction.f
+incdir+rtl
rtl/gcr_pkg.sv
rtl/gcr_in_if.sv
rtl/gcr_out_if.sv
rtl/gcr_front.sv
rtl/gcr_fifo.sv
rtl/gcr_back.sv
rtl/gf2_column_reduction.sv
verif/tb_gf2_column_reduction.sv
